// ----- rtl/cjps_pkg.sv -----
// Package for the cycle jump pitch shifter.
// Field widths, fixed-point constants and register indexes shared by the RTL.
// No dependencies.
package cjps_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PERIOD_W = 27;
  localparam int RATE_W   = 18;
  localparam int GAIN_W   = 17;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // 1.0 in the Q.16 formats
  localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(6554);

  // register index, taken from paddr[2]
  localparam logic REG_SNAP = 1'b0;
  localparam logic REG_GAIN = 1'b1;

endpackage

// ----- rtl/cjps_ring.sv -----
// Sample ring for the pitch shifter: one write port, one registered read port.
// Entries never written since reset read as zero, tracked by a fill count.
// Depends on cjps_pkg.
module cjps_ring #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                wr_en_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic signed [cjps_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic                                rd_en_i,
  input  logic [AW-1:0]                       rd_addr_i,
  output logic signed [cjps_pkg::SAMPLE_W-1:0] rd_data_o
);
  import cjps_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);

  logic signed [SAMPLE_W-1:0] mem_q [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_raw_q;
  logic                       rd_ok_q, rd_ok_d;
  logic [FILL_W-1:0]          fill_q, fill_d;

  // writes go in address order from reset, so entry i is written iff i < fill
  always_comb begin
    fill_d = fill_q;
    if (wr_en_i && (fill_q != FILL_W'(DEPTH))) begin
      fill_d = fill_q + FILL_W'(1);
    end
    rd_ok_d = rd_ok_q;
    if (rd_en_i) begin
      rd_ok_d = FILL_W'(rd_addr_i) < fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_raw_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_ok_q ? rd_raw_q : '0;

endmodule

// ----- rtl/cycle_jump_pitch_shifter.sv -----
// Cycle jump pitch shifter: resampling read of a sample ring with period splice.
// Inputs are stalled while an item is in the sequencer, so a new item is taken
// only after the last one has been loaded to the output; the sequencer shares one
// 19x18 multiplier (rate smoothing, then interpolation) and two reads on the single ring read port.
// Reset: rate and lag go to 1.0, write index to 0, the ring reads as zeros
// (fill count, no clearing pass); snap_mode 0, rate_gain 6554.
module cycle_jump_pitch_shifter #(
  parameter int RING_DEPTH = 2048,
  parameter int LOOKAHEAD  = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cjps_pkg::APB_AW-1:0]          paddr,
  input  logic [cjps_pkg::APB_DW-1:0]          pwdata,
  output logic [cjps_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [cjps_pkg::SAMPLE_W-1:0] in_sample_i,
  input  logic [cjps_pkg::PERIOD_W-1:0]        cycle_period_i,
  input  logic [cjps_pkg::RATE_W-1:0]          target_rate_i,
  input  logic                                 update_rate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [cjps_pkg::SAMPLE_W-1:0] out_sample_o
);
  import cjps_pkg::*;

  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int DEPTH_W = $clog2(RING_DEPTH + 1);
  localparam int LAG_W   = ((DEPTH_W + 16 > PERIOD_W + 1) ? DEPTH_W + 16 : PERIOD_W + 1) + 2;
  localparam int MA_W    = RATE_W + 1;
  localparam int MB_W    = GAIN_W + 1;
  localparam int P_W     = MA_W + MB_W;

  localparam logic signed [LAG_W-1:0] ONE_L   = LAG_W'(65536);
  localparam logic signed [LAG_W-1:0] RING_Q  = LAG_W'(RING_DEPTH) << 16;
  localparam logic signed [LAG_W-1:0] LA_Q    = LAG_W'(LOOKAHEAD) << 16;
  localparam logic signed [LAG_W-1:0] LAG_MIN = ONE_L + LAG_W'(1) - LA_Q;
  localparam logic signed [LAG_W-1:0] LAG_MAX = RING_Q - LA_Q;
  localparam logic [RING_AW-1:0]      IDX_LAST = RING_AW'(RING_DEPTH - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_RATE_MUL = 3'd1;
  localparam logic [2:0] ST_RATE     = 3'd2;
  localparam logic [2:0] ST_LAG      = 3'd3;
  localparam logic [2:0] ST_ADDR     = 3'd4;
  localparam logic [2:0] ST_RD1      = 3'd5;
  localparam logic [2:0] ST_MUL_IP   = 3'd6;
  localparam logic [2:0] ST_OUT      = 3'd7;

  logic [2:0] state_q, state_d;

  logic              snap_q, snap_d;
  logic [GAIN_W-1:0] gain_q, gain_d;

  logic [RING_AW-1:0]       wi_q, wi_d;
  logic signed [LAG_W-1:0]  lag_q, lag_d;
  logic [RATE_W-1:0]        rate_q, rate_d;
  logic                     out_valid_q, out_valid_d;

  // payload registers
  logic [PERIOD_W-1:0]        period_q;
  logic [RATE_W-1:0]          target_q;
  logic                       update_q;
  logic [RING_AW-1:0]         i1_q;
  logic [15:0]                frac_q;
  logic signed [SAMPLE_W-1:0] s0_q;
  logic signed [P_W-1:0]      prod_q;
  logic signed [SAMPLE_W-1:0] out_q;

  logic cfg_wr, in_acc, out_load;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [P_W-1:0]  mul_p;

  logic [GAIN_W-1:0]          gain_eff;
  logic [P_W-1:0]             prod_mag;
  logic [P_W-1:0]             prod_rnd;
  logic signed [MA_W:0]       rate_step;
  logic signed [MA_W:0]       rate_sum;

  logic signed [LAG_W-1:0] rate_l, period_l, lag_sub, lag_spl, lag_clamp;
  logic signed [LAG_W-1:0] pos_raw, pos;
  logic [RING_AW-1:0]      i0;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W:0]   s_diff;
  logic signed [P_W-1:0]      ip_acc;

  logic               rd_en;
  logic [RING_AW-1:0] rd_addr;

  // ---- configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    snap_d = snap_q;
    gain_d = gain_q;
    if (cfg_wr) begin
      case (paddr[2])
        REG_SNAP: snap_d = pwdata[0];
        REG_GAIN: gain_d = pwdata[GAIN_W-1:0];
        default:  snap_d = snap_q;
      endcase
    end
  end

  assign prdata = paddr[2] ? APB_DW'(gain_q) : APB_DW'(snap_q);

  // ---- handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_sample_o = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // ---- shared multiplier
  assign gain_eff = (gain_q > ONE_Q16) ? ONE_Q16 : gain_q;
  assign s_diff   = (SAMPLE_W+1)'(rd_data) - (SAMPLE_W+1)'(s0_q);

  always_comb begin
    case (state_q)
      ST_RATE_MUL: begin
        mul_a = $signed({1'b0, target_q}) - $signed({1'b0, rate_q});
        mul_b = $signed({1'b0, gain_eff});
      end
      default: begin
        mul_a = MA_W'(s_diff);
        mul_b = $signed(MB_W'(frac_q));
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // ---- rate update: round half away from zero
  assign prod_mag  = prod_q[P_W-1] ? P_W'(-prod_q) : P_W'(prod_q);
  assign prod_rnd  = (prod_mag + P_W'(32768)) >> 16;
  assign rate_step = prod_q[P_W-1] ? -$signed((MA_W+1)'(prod_rnd))
                                   :  $signed((MA_W+1)'(prod_rnd));
  assign rate_sum  = $signed({2'b00, rate_q}) + rate_step;

  always_comb begin
    rate_d = rate_q;
    if (state_q == ST_RATE) begin
      if (period_q == '0) begin
        rate_d = RATE_W'(ONE_Q16);
      end else if (update_q) begin
        rate_d = snap_q ? target_q : rate_sum[RATE_W-1:0];
      end
    end
  end

  // ---- lag: step, period splice, clamp
  assign rate_l   = $signed(LAG_W'(rate_q));
  assign period_l = $signed(LAG_W'(period_q));
  assign lag_sub  = lag_q - rate_l;

  always_comb begin
    lag_spl = lag_sub;
    if (period_q != '0) begin
      if ((rate_q > RATE_W'(ONE_Q16)) && (lag_sub < 0)) begin
        lag_spl = lag_sub + period_l;
      end else if ((rate_q <= RATE_W'(ONE_Q16)) && (lag_sub > period_l)) begin
        lag_spl = lag_sub - period_l;
      end
    end
    lag_clamp = lag_spl;
    if (lag_clamp > LAG_MAX) lag_clamp = LAG_MAX;
    if (lag_clamp < LAG_MIN) lag_clamp = LAG_MIN;
  end

  always_comb begin
    lag_d = lag_q;
    if (in_acc) begin
      lag_d = lag_q + ONE_L;
    end else if (state_q == ST_LAG) begin
      lag_d = lag_clamp;
    end
  end

  // ---- read position; distance lies in (1.0, ring], one wrap at most
  assign pos_raw = $signed(LAG_W'({wi_q, 16'd0})) - (lag_q + LA_Q);
  assign pos     = (pos_raw < 0) ? pos_raw + RING_Q : pos_raw;
  assign i0      = pos[16 +: RING_AW];

  // ---- write index
  assign wi_d = in_acc ? ((wi_q == IDX_LAST) ? '0 : wi_q + RING_AW'(1)) : wi_q;

  // ---- ring reads
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = i0;
    case (state_q)
      ST_ADDR: rd_en = 1'b1;
      ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = i1_q;
      end
      default: rd_en = 1'b0;
    endcase
  end

  cjps_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (RING_AW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_addr_i (wi_q),
    .wr_data_i (in_sample_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // s0 + (s1 - s0) * frac, rounded half up
  assign ip_acc = (P_W'(s0_q) <<< 16) + prod_q + P_W'(32768);

  // ---- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_acc) state_d = ST_RATE_MUL;
      ST_RATE_MUL: state_d = ST_RATE;
      ST_RATE:     state_d = ST_LAG;
      ST_LAG:      state_d = ST_ADDR;
      ST_ADDR:     state_d = ST_RD1;
      ST_RD1:      state_d = ST_MUL_IP;
      ST_MUL_IP:   state_d = ST_OUT;
      ST_OUT:      if (out_load) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      snap_q      <= 1'b0;
      gain_q      <= GAIN_RESET;
      wi_q        <= '0;
      lag_q       <= ONE_L;
      rate_q      <= RATE_W'(ONE_Q16);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      snap_q      <= snap_d;
      gain_q      <= gain_d;
      wi_q        <= wi_d;
      lag_q       <= lag_d;
      rate_q      <= rate_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      period_q <= cycle_period_i;
      target_q <= target_rate_i;
      update_q <= update_rate_i;
    end
    if (state_q == ST_RATE_MUL || state_q == ST_MUL_IP) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_ADDR) begin
      i1_q   <= (i0 == IDX_LAST) ? '0 : i0 + RING_AW'(1);
      frac_q <= pos[15:0];
    end
    if (state_q == ST_RD1) begin
      s0_q <= rd_data;
    end
    if (out_load) begin
      out_q <= ip_acc[31:16];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cycle_jump_pitch_shifter: ring write, rate smoothing,
// period splice and interpolated read, all predicted in-line and checked per transaction.
// Depends on cjps_pkg, rtl/cycle_jump_pitch_shifter.sv and, through it, rtl/cjps_ring.sv.
module tb_top;
  import cjps_pkg::*;

  localparam int     RING_DEPTH = 2048;
  localparam int     LOOKAHEAD  = 64;
  localparam longint UNITY      = longint'(ONE_Q16);
  localparam longint RING_Q16   = longint'(RING_DEPTH) * UNITY;
  localparam longint LAG_FLOOR  = UNITY + 1 - longint'(LOOKAHEAD) * UNITY;
  localparam longint LAG_CEIL   = RING_Q16 - longint'(LOOKAHEAD) * UNITY;
  localparam int     SETTLE     = 8;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;
  localparam logic [RATE_W-1:0]   TARGET_MAX = '1;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic [PERIOD_W-1:0]        period;
    logic [RATE_W-1:0]          target;
    logic                       upd;
  } voice_in_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [APB_AW-1:0]          paddr   = '0;
  logic [APB_DW-1:0]          pwdata  = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] in_sample_i    = '0;
  logic [PERIOD_W-1:0]        cycle_period_i = '0;
  logic [RATE_W-1:0]          target_rate_i  = '0;
  logic                       update_rate_i  = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic signed [SAMPLE_W-1:0] out_sample_o;

  cycle_jump_pitch_shifter #(
    .RING_DEPTH(RING_DEPTH),
    .LOOKAHEAD (LOOKAHEAD)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_sample_i   (in_sample_i),
    .cycle_period_i(cycle_period_i),
    .target_rate_i (target_rate_i),
    .update_rate_i (update_rate_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_sample_o  (out_sample_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow state of the shifter
  logic signed [SAMPLE_W-1:0] voice_ring [RING_DEPTH];
  int                         wr_ptr;
  longint                     lag_q16;
  longint                     rate_q16;
  logic                       snap_on;
  logic [GAIN_W-1:0]          gain_q16;

  voice_in_t                  pending_frames [$];
  logic signed [SAMPLE_W-1:0] expected_samples [$];
  voice_in_t                  on_bus;
  int                         mismatches  = 0;
  int                         in_idle_pct = 0;
  int                         out_idle_pct = 0;
  int                         in_gap = 0;
  int                         out_gap = 0;
  bit                         calm = 1'b0;

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: %s", $time, what);
  endtask

  // One sample through the shifter: write, rate update, lag advance and splice,
  // clamp, then linear interpolation at lag + LOOKAHEAD behind the write point.
  task automatic resample_and_splice(input voice_in_t it,
                                     output logic signed [SAMPLE_W-1:0] y);
    longint per, tgt, g, diff, mag, step, rd_span, pos, frac, acc;
    int     i0, i1;
    voice_ring[wr_ptr] = it.smp;
    wr_ptr  = (wr_ptr + 1) % RING_DEPTH;
    lag_q16 = lag_q16 + UNITY;
    per = longint'(it.period);
    tgt = longint'(it.target);
    if (per > 0) begin
      if (it.upd) begin
        if (snap_on) begin
          rate_q16 = tgt;
        end else begin
          g    = (longint'(gain_q16) > UNITY) ? UNITY : longint'(gain_q16);
          diff = (tgt - rate_q16) * g;
          mag  = (diff < 0) ? -diff : diff;
          step = (mag + 32768) >>> 16;
          rate_q16 = rate_q16 + ((diff < 0) ? -step : step);
        end
      end
    end else begin
      rate_q16 = UNITY;
    end
    lag_q16 = lag_q16 - rate_q16;
    if (per > 0) begin
      if (rate_q16 > UNITY && lag_q16 < 0) lag_q16 = lag_q16 + per;
      else if (rate_q16 <= UNITY && lag_q16 > per) lag_q16 = lag_q16 - per;
    end
    if (lag_q16 > LAG_CEIL) lag_q16 = LAG_CEIL;
    if (lag_q16 < LAG_FLOOR) lag_q16 = LAG_FLOOR;
    rd_span = lag_q16 + longint'(LOOKAHEAD) * UNITY;
    pos  = (longint'(wr_ptr) * UNITY - rd_span) % RING_Q16;
    if (pos < 0) pos = pos + RING_Q16;
    i0   = int'((pos >>> 16) % RING_DEPTH);
    i1   = (i0 + 1) % RING_DEPTH;
    frac = pos & 64'hFFFF;
    acc  = longint'(voice_ring[i0]) * (UNITY - frac) + longint'(voice_ring[i1]) * frac;
    acc  = ((acc + 64'sd2147483648 + 32768) >>> 16) - 32768;
    y    = acc[SAMPLE_W-1:0];
  endtask

  // sender: accept, predict, then either idle or present the next transaction
  always @(posedge clk_i) begin : drive_inputs
    logic                       load;
    logic signed [SAMPLE_W-1:0] y;
    if (rst_ni) begin
      load = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        resample_and_splice(on_bus, y);
        expected_samples.push_back(y);
        load = 1'b0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          load = 1'b0;
        end else if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 6);
          load = 1'b0;
        end else if (pending_frames.size() > 0) begin
          on_bus         = pending_frames.pop_front();
          in_sample_i    <= on_bus.smp;
          cycle_period_i <= on_bus.period;
          target_rate_i  <= on_bus.target;
          update_rate_i  <= on_bus.upd;
          load = 1'b1;
        end
      end
      in_valid_i <= load;
    end
  end

  // receiver: check each output transaction, stall in bursts
  always @(posedge clk_i) begin : collect_outputs
    logic                       hold;
    logic signed [SAMPLE_W-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected out_sample %0d", out_sample_o));
        end else begin
          want = expected_samples.pop_front();
          if (out_sample_o !== want)
            report_mismatch($sformatf("out_sample %0d, predicted %0d", out_sample_o, want));
        end
      end
      hold = 1'b0;
      if (out_gap > 0) begin
        out_gap--;
        hold = 1'b1;
      end else if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 6);
        hold = 1'b1;
      end
      out_stall_i <= hold;
    end
  end

  task automatic set_reg(input logic idx, input logic [APB_DW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_SNAP) snap_on = val[0];
    else gain_q16 = val[GAIN_W-1:0];
    // read back
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== val)
      report_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, prdata, val));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_frame(input logic signed [SAMPLE_W-1:0] s, input logic [PERIOD_W-1:0] p,
                           input logic [RATE_W-1:0] t, input logic u);
    voice_in_t it;
    it.smp    = s;
    it.period = p;
    it.target = t;
    it.upd    = u;
    pending_frames.push_back(it);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    return SAMPLE_W'($urandom);
  endfunction

  // a run of transactions sharing one character: mostly voiced with a steady
  // period, some unvoiced, some splice-heavy, some plain noise
  task automatic queue_voice_segment(input int n);
    int                  kind;
    logic [PERIOD_W-1:0] base;
    logic [RATE_W-1:0]   tgt;
    kind = $urandom_range(0, 9);
    base = PERIOD_W'($urandom_range(20 << 16, 600 << 16));
    tgt  = RATE_W'($urandom_range(32768, 131072));
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: add_frame(pick_sample(), '0, RATE_W'($urandom), 1'($urandom));
        1: add_frame(pick_sample(), PERIOD_W'($urandom), RATE_W'($urandom), 1'($urandom));
        2: add_frame(pick_sample(), PERIOD_W'($urandom_range(1, 8 << 16)),
                     RATE_W'($urandom_range(131072, 262143)), 1'b1);
        3: add_frame(pick_sample(), $urandom_range(0, 1) ? PERIOD_MAX : PERIOD_W'($urandom),
                     RATE_W'($urandom), 1'b1);
        default: add_frame(pick_sample(),
                           base + PERIOD_W'($urandom_range(0, 2 << 16)) - PERIOD_W'(1 << 16),
                           tgt, $urandom_range(0, 9) < 8);
      endcase
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    @(negedge clk_i);
    while ((pending_frames.size() > 0 || in_valid_i || expected_samples.size() > 0)
           && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_samples.size() > 0) begin
      report_mismatch($sformatf("%0d output transactions never arrived",
                                expected_samples.size()));
      expected_samples.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int queued;
    int n;
    foreach (voice_ring[k]) voice_ring[k] = '0;
    wr_ptr   = 0;
    lag_q16  = UNITY;
    rate_q16 = UNITY;
    snap_on  = 1'b0;
    gain_q16 = GAIN_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset config, unvoiced, field extremes, smoothing both ways
    in_idle_pct  = 30;
    out_idle_pct = 30;
    add_frame(16'sh7FFF, '0, '0, 1'b1);
    add_frame(16'sh8000, '0, TARGET_MAX, 1'b0);
    add_frame(16'sh5555, PERIOD_W'(100 << 16), TARGET_MAX, 1'b1);
    add_frame(-16'sd21846, PERIOD_W'(100 << 16), TARGET_MAX, 1'b0);
    add_frame(16'sd1, PERIOD_MAX, '0, 1'b1);
    add_frame(-16'sd1, PERIOD_MAX, '0, 1'b1);
    add_frame(16'sd0, PERIOD_W'(1), RATE_W'(131072), 1'b1);
    add_frame(16'sh7FFF, PERIOD_W'(1), RATE_W'(131072), 1'b1);
    add_frame(16'sh8000, PERIOD_W'(64 << 16), RATE_W'(65536), 1'b1);
    add_frame(16'sd100, '0, RATE_W'(65536), 1'b1);
    wait_drained();
    // gain above one behaves as one
    set_reg(REG_GAIN, 131071);
    add_frame(16'sd7, PERIOD_W'(300 << 16), RATE_W'(98304), 1'b1);
    add_frame(-16'sd7, PERIOD_W'(300 << 16), '0, 1'b1);
    wait_drained();
    // snap: upper lag clamp, rate zero, rate exactly and just above unity
    set_reg(REG_SNAP, 1);
    set_reg(REG_GAIN, 0);
    add_frame(16'sd1000, PERIOD_MAX, TARGET_MAX, 1'b1);
    add_frame(-16'sd1000, PERIOD_W'(2 << 16), '0, 1'b1);
    add_frame(16'sd2000, PERIOD_W'(2 << 16), '0, 1'b0);
    add_frame(-16'sd2000, PERIOD_W'(2 << 16), RATE_W'(65536), 1'b1);
    add_frame(16'sd3000, PERIOD_W'(2 << 16), RATE_W'(65537), 1'b1);
    add_frame(-16'sd3000, PERIOD_W'(5), TARGET_MAX, 1'b1);
    add_frame(16'sh7FFF, PERIOD_W'(5), TARGET_MAX, 1'b1);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin set_reg(REG_SNAP, 0); set_reg(REG_GAIN, GAIN_RESET);
                 in_idle_pct = 25; out_idle_pct = 25; end
        1: begin set_reg(REG_SNAP, 1); set_reg(REG_GAIN, 0);
                 in_idle_pct = 50; out_idle_pct = 10; end
        2: begin set_reg(REG_SNAP, 0);
                 in_idle_pct = 0; out_idle_pct = 0; end
        3: begin set_reg(REG_GAIN, 65536);
                 in_idle_pct = 10; out_idle_pct = 60; end
        4: begin set_reg(REG_GAIN, 131071);
                 in_idle_pct = 40; out_idle_pct = 40; end
        default: begin set_reg(REG_GAIN, $urandom_range(1, 65535));
                       calm = 1'b1; end
      endcase
      queued = 0;
      while (queued < 100) begin
        n = $urandom_range(5, 40);
        if (n > 100 - queued) n = 100 - queued;
        queue_voice_segment(n);
        queued += n;
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("cycle_jump_pitch_shifter: match");
    end else begin
      $display("cycle_jump_pitch_shifter: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("cycle_jump_pitch_shifter: mismatch");
    $finish;
  end

endmodule
